// ===== rtl/deq_pkg.sv =====
// Shared types and constants for the double-ended queue.
// Used by deq_cell, double_ended_queue_top and the testbench; depends on nothing.
package deq_pkg;

	localparam int DATA_W    = 32;
	localparam int DEPTH_DEF = 16;

	localparam logic [DATA_W-1:0] EMPTY_MARK = '1;

	// Operation codes carried by an input item
	localparam logic [1:0] FN_PUSH_HEAD = 2'd0;
	localparam logic [1:0] FN_PUSH_TAIL = 2'd1;
	localparam logic [1:0] FN_POP_HEAD  = 2'd2;
	localparam logic [1:0] FN_POP_TAIL  = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER  = 2'd2;

	// Per-cycle command broadcast to every cell in the row
	typedef struct packed {
		logic shift_right; // push front: each cell takes its left neighbor
		logic shift_left;  // pop front: each cell takes its right neighbor
		logic write_back;  // push back: the cell at the fill position loads the value
	} ctl_t;

endpackage

// ===== rtl/double_ended_queue_top.sv =====
// Double-ended queue top level: a row of deq_cell entries with front at cell 0.
// Depends on deq_pkg and deq_cell.
//
//  channel  | handshake        | payload
//  ---------+------------------+--------------------------------------------------
//  command  | start, busy      | func, value
//  result   | done (strobe)    | status, popped_value, front_value, back_value,
//           |                  | is_empty, fill_count
//
// The result strobes on done in the cycle after start, and busy stays low,
// so a new item may enter each cycle.
// The front sits in cell 0; front pushes and pops shift the whole cell row by
// one place, back pushes load the cell at the fill position, and the entry
// before the back comes from an OR chain through the cells.
// Reset clears the fill count and the strobe; cell contents are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module double_ended_queue_top #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           func,
	input  logic signed [deq_pkg::DATA_W-1:0]    value,
	output logic                                 done,
	output logic [1:0]                           status,
	output logic signed [deq_pkg::DATA_W-1:0]    popped_value,
	output logic signed [deq_pkg::DATA_W-1:0]    front_value,
	output logic signed [deq_pkg::DATA_W-1:0]    back_value,
	output logic                                 is_empty,
	output logic [CNT_W-1:0]                     fill_count
);
	import deq_pkg::*;

	logic              accept;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_nxt;
	logic [DATA_W-1:0] back_q;
	logic [DATA_W-1:0] back_nxt;
	logic              empty;
	logic              full;
	ctl_t              ctl;

	logic [DATA_W-1:0] cell_data [DEPTH];
	logic [DATA_W-1:0] sel_chain [DEPTH+1];

	logic              done_q;
	logic [1:0]        status_q, status_nxt;
	logic [DATA_W-1:0] popped_q, popped_nxt;
	logic [DATA_W-1:0] front_q,  front_nxt;
	logic [DATA_W-1:0] back_out_q;
	logic              empty_q;
	logic [CNT_W-1:0]  fill_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign empty  = (count_q == '0);
	assign full   = (32'(count_q) == DEPTH);

	// Decode the operation into cell commands and the next snapshot
	always_comb begin
		ctl        = '0;
		count_nxt  = count_q;
		back_nxt   = back_q;
		status_nxt = ST_DONE;
		popped_nxt = '0;
		front_nxt  = cell_data[0];
		unique case (func)
			FN_PUSH_HEAD: begin
				if (full) begin
					status_nxt = ST_OVER;
				end else begin
					ctl.shift_right = accept;
					count_nxt       = count_q + CNT_W'(1);
					front_nxt       = value;
					if (empty) begin
						back_nxt = value;
					end
				end
			end
			FN_PUSH_TAIL: begin
				if (full) begin
					status_nxt = ST_OVER;
				end else begin
					ctl.write_back = accept;
					count_nxt      = count_q + CNT_W'(1);
					back_nxt       = value;
					if (empty) begin
						front_nxt = value;
					end
				end
			end
			FN_POP_HEAD: begin
				if (empty) begin
					status_nxt = ST_UNDER;
				end else begin
					ctl.shift_left = accept;
					count_nxt      = count_q - CNT_W'(1);
					popped_nxt     = cell_data[0];
					front_nxt      = cell_data[1];
				end
			end
			FN_POP_TAIL: begin
				if (empty) begin
					status_nxt = ST_UNDER;
				end else begin
					count_nxt  = count_q - CNT_W'(1);
					popped_nxt = back_q;
					back_nxt   = sel_chain[DEPTH];
				end
			end
			default: begin
				status_nxt = ST_DONE;
			end
		endcase
	end

	// Build the cell row
	assign sel_chain[0] = '0;
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] left_d;
		logic [DATA_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = value;
		end else begin : g_mid
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_inner
			assign right_d = cell_data[i+1];
		end
		deq_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count_q),
			.wr_data    (value),
			.left_data  (left_d),
			.right_data (right_d),
			.sel_in     (sel_chain[i]),
			.data       (cell_data[i]),
			.sel_out    (sel_chain[i+1])
		);
	end

	// Hold the fill count and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_nxt;
			end
		end
	end

	// Capture the back entry and the result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			back_q     <= back_nxt;
			status_q   <= status_nxt;
			popped_q   <= popped_nxt;
			fill_q     <= count_nxt;
			empty_q    <= (count_nxt == '0);
			if (count_nxt == '0) begin
				front_q    <= EMPTY_MARK;
				back_out_q <= EMPTY_MARK;
			end else begin
				front_q    <= front_nxt;
				back_out_q <= back_nxt;
			end
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign popped_value = popped_q;
	assign front_value  = front_q;
	assign back_value   = back_out_q;
	assign is_empty     = empty_q;
	assign fill_count   = fill_q;

	// Fill count never passes the row length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= DEPTH)
		else $error("fill count exceeds depth");

	// A result strobes in the cycle after each accepted item
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted item gave no result");

	// Empty flag agrees with the reported count
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_empty == (fill_count == '0)))
		else $error("empty flag disagrees with count");

	// Underflow only on an empty queue, overflow only on a full one
	a_under_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_UNDER) |-> (is_empty && popped_value == '0))
		else $error("underflow on a non-empty queue");

	a_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_OVER) |-> (32'(fill_count) == DEPTH))
		else $error("overflow on a non-full queue");

	// Count changes only when an item is accepted
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("fill count changed with no item");

endmodule

// ===== rtl/deq_cell.sv =====
// One storage cell of the queue row: holds one entry, shifts with its neighbors.
// Depends on deq_pkg (ctl_t, DATA_W).
module deq_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 5
) (
	input  logic                          clk,
	input  deq_pkg::ctl_t                 ctl,
	input  logic [CNT_W-1:0]              count,
	input  logic [deq_pkg::DATA_W-1:0]    wr_data,
	input  logic [deq_pkg::DATA_W-1:0]    left_data,
	input  logic [deq_pkg::DATA_W-1:0]    right_data,
	input  logic [deq_pkg::DATA_W-1:0]    sel_in,
	output logic [deq_pkg::DATA_W-1:0]    data,
	output logic [deq_pkg::DATA_W-1:0]    sel_out
);
	import deq_pkg::*;

	logic [DATA_W-1:0] data_q;
	logic              at_fill;
	logic              at_prev_back;

	// Locate this cell relative to the fill position
	assign at_fill      = (32'(count) == IDX);
	assign at_prev_back = (32'(count) == IDX + 2);

	// Advance the entry: shift in from a neighbor or load a pushed value
	always_ff @(posedge clk) begin
		if (ctl.shift_right) begin
			data_q <= left_data;
		end else if (ctl.shift_left) begin
			data_q <= right_data;
		end else if (ctl.write_back && at_fill) begin
			data_q <= wr_data;
		end
	end

	assign data = data_q;

	// Pass the entry just ahead of the back along the select chain
	assign sel_out = sel_in | (data_q & {DATA_W{at_prev_back}});

endmodule

// ===== sim/tb_double_ended_queue_top.sv =====
// Self-checking testbench for double_ended_queue_top: random and directed deque operations.
// Each result is checked against an in-bench ring-buffer predictor.
// Depends on deq_pkg and the double_ended_queue_top RTL.
module tb_double_ended_queue_top;
	timeunit 1ns;
	timeprecision 1ps;

	import deq_pkg::*;

	localparam int QDEPTH      = 16;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] popped;
		logic signed [DATA_W-1:0] front;
		logic signed [DATA_W-1:0] back;
		logic                     empty;
		logic [4:0]               count;
	} deq_snapshot_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [1:0]               func;
	logic signed [DATA_W-1:0] value;
	logic                     done;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] popped_value;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] back_value;
	logic                     is_empty;
	logic [4:0]               fill_count;

	// Predictor state: ring of entries, front index and entry count
	logic signed [DATA_W-1:0] ring_slots [QDEPTH];
	logic [3:0]               ring_head;
	logic [4:0]               ring_count;

	deq_snapshot_t pending_snapshots[$];
	int            mismatch_count;
	int            cycle_count;

	double_ended_queue_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.value        (value),
		.done         (done),
		.status       (status),
		.popped_value (popped_value),
		.front_value  (front_value),
		.back_value   (back_value),
		.is_empty     (is_empty),
		.fill_count   (fill_count)
	);

	always #5 clk = ~clk;

	// Apply one operation to the predicted deque and return the snapshot it yields
	function automatic deq_snapshot_t apply_deque_op(input logic [1:0] op,
			input logic signed [DATA_W-1:0] v);
		deq_snapshot_t r;
		logic [3:0]    tail;
		r = '0;
		r.status = ST_DONE;
		case (op)
			FN_PUSH_HEAD, FN_PUSH_TAIL: begin
				if (ring_count == QDEPTH) begin
					r.status = ST_OVER;
				end else if (op == FN_PUSH_HEAD) begin
					ring_head = ring_head - 4'd1;
					ring_slots[ring_head] = v;
					ring_count = ring_count + 5'd1;
				end else begin
					tail = ring_head + ring_count[3:0];
					ring_slots[tail] = v;
					ring_count = ring_count + 5'd1;
				end
			end
			default: begin
				if (ring_count == 0) begin
					r.status = ST_UNDER;
				end else if (op == FN_POP_HEAD) begin
					r.popped = ring_slots[ring_head];
					ring_head = ring_head + 4'd1;
					ring_count = ring_count - 5'd1;
				end else begin
					tail = ring_head + ring_count[3:0] - 4'd1;
					r.popped = ring_slots[tail];
					ring_count = ring_count - 5'd1;
				end
			end
		endcase
		// Snapshot after the operation; a full ring wraps the count to zero in 4 bits
		if (ring_count == 0) begin
			r.front = EMPTY_MARK;
			r.back  = EMPTY_MARK;
			r.empty = 1'b1;
		end else begin
			tail = ring_head + ring_count[3:0] - 4'd1;
			r.front = ring_slots[ring_head];
			r.back  = ring_slots[tail];
			r.empty = 1'b0;
		end
		r.count = ring_count;
		return r;
	endfunction

	// Check each result against the oldest snapshot, then predict any accepted item
	always @(posedge clk) begin
		deq_snapshot_t seen;
		deq_snapshot_t want;
		if (arst_n) begin
			if (done) begin
				seen.status = status;
				seen.popped = popped_value;
				seen.front  = front_value;
				seen.back   = back_value;
				seen.empty  = is_empty;
				seen.count  = fill_count;
				if (pending_snapshots.size() == 0) begin
					mismatch_count++;
					$display("%0t: result with no item pending: status=%0d popped=%0d",
						$time, seen.status, seen.popped);
				end else begin
					want = pending_snapshots[0];
					pending_snapshots.delete(0);
					if (seen !== want) begin
						mismatch_count++;
						$display("%0t: expected st=%0d pop=%0d fr=%0d bk=%0d em=%0d n=%0d",
							$time, want.status, want.popped, want.front, want.back,
							want.empty, want.count);
						$display("%0t: actual   st=%0d pop=%0d fr=%0d bk=%0d em=%0d n=%0d",
							$time, seen.status, seen.popped, seen.front, seen.back,
							seen.empty, seen.count);
					end
				end
			end
			if (start && !busy)
				pending_snapshots.insert(pending_snapshots.size(),
					apply_deque_op(func, value));
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("double_ended_queue_top: mismatch");
			$finish;
		end
	end

	// Hold one item on the command ports until it is accepted
	task automatic send_item(input logic [1:0] op, input logic signed [DATA_W-1:0] v);
		start <= 1'b1;
		func  <= op;
		value <= v;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Drop start for a number of cycles, with noise on the payload
	task automatic idle_cycles(input int n);
		if (n > 0) begin
			start <= 1'b0;
			func  <= 2'($urandom);
			value <= $urandom;
			repeat (n) @(posedge clk);
		end
	endtask

	// Hold off the sender until every pending result has come back
	task automatic wait_for_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_snapshots.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return -32'sd1;
			3: return 32'sd0;
			default: return $urandom;
		endcase
	endfunction

	// Pops on an empty deque underflow; the value sent is ignored
	task automatic test_empty_pops();
		send_item(FN_POP_HEAD, 32'sh7FFF_FFFF);
		send_item(FN_POP_TAIL, 32'sh8000_0000);
	endtask

	// One entry is both front and back
	task automatic test_single_entry();
		send_item(FN_PUSH_TAIL, 32'sh7FFF_FFFF);
		send_item(FN_POP_HEAD, 32'sd0);
		idle_cycles(2);
		send_item(FN_PUSH_HEAD, 32'sh8000_0000);
		send_item(FN_POP_TAIL, -32'sd1);
	endtask

	// Fill from both ends, then push on a full deque
	task automatic test_fill_to_overflow();
		for (int i = 0; i < QDEPTH; i++) begin
			if (i % 2 == 0)
				send_item(FN_PUSH_HEAD, (i == 0) ? -32'sd1 : pick_value());
			else
				send_item(FN_PUSH_TAIL, (i == 1) ? 32'sd0 : pick_value());
			if (i % 5 == 4)
				idle_cycles($urandom_range(1, 3));
		end
		send_item(FN_PUSH_HEAD, 32'sh1234_5678);
		send_item(FN_PUSH_TAIL, 32'sh8765_4321);
	endtask

	// Bursts of random operations with a given share of pushes
	task automatic run_random_burst(input int total, input int push_pct);
		int         sent;
		int         burst_len;
		logic [1:0] op;
		sent = 0;
		while (sent < total) begin
			burst_len = $urandom_range(1, 24);
			for (int i = 0; i < burst_len && sent < total; i++) begin
				if ($urandom_range(0, 99) < push_pct)
					op = $urandom_range(0, 1) ? FN_PUSH_TAIL : FN_PUSH_HEAD;
				else
					op = $urandom_range(0, 1) ? FN_POP_TAIL : FN_POP_HEAD;
				send_item(op, pick_value());
				sent++;
			end
			// Leave no gap now and then so back-to-back stretches occur
			if ($urandom_range(0, 3) != 0)
				idle_cycles($urandom_range(1, 8));
		end
	endtask

	// Swing between filling and draining so both ends hit overflow and underflow
	task automatic test_random_mix();
		run_random_burst(50, 15);
		run_random_burst(50, 85);
		run_random_burst(50, 95);
		wait_for_results();
		run_random_burst(50, 5);
		run_random_burst(50, 50);
		run_random_burst(50, 70);
		run_random_burst(50, 30);
		run_random_burst(50, 60);
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		start          = 1'b0;
		func           = FN_PUSH_HEAD;
		value          = '0;
		mismatch_count = 0;
		cycle_count    = 0;
		ring_head      = '0;
		ring_count     = '0;
		for (int i = 0; i < QDEPTH; i++)
			ring_slots[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_pops();
		test_single_entry();
		test_fill_to_overflow();
		wait_for_results();
		test_random_mix();

		// Drain, then keep clocking so any stray result is seen
		wait_for_results();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && pending_snapshots.size() == 0) begin
			$display("double_ended_queue_top: match");
		end else begin
			$display("double_ended_queue_top: mismatch");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/deq_pkg.sv
rtl/deq_cell.sv
rtl/double_ended_queue_top.sv
sim/tb_double_ended_queue_top.sv
